// ===== hdl/cache_way_partition_dp_assert.svh =====
`ifndef CACHE_WAY_PARTITION_DP_ASSERT_SVH
`define CACHE_WAY_PARTITION_DP_ASSERT_SVH

// same-cycle implication
`define CWP_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CWP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/cwp_pkg.sv =====
package cwp_pkg;

    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 72;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 17;

    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_WAYS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SETS       = 2'd1;

    localparam logic [4:0]  TOTAL_WAYS_RST = 5'd16;
    localparam logic [16:0] SETS_RST       = 17'd1024;

    localparam int LINES_W = 23;
    localparam int X_W     = 30;
    localparam int XS_W    = 28;
    localparam int PROD_W  = 56;

    localparam logic [6:0]      MUL_HI    = 7'd105;
    localparam logic [6:0]      MUL_LO    = 7'd95;
    localparam logic [XS_W-1:0] DIV25_MAG = 28'd171798692;

    typedef struct packed {
        logic idle;
        logic init;
        logic rd;
        logic wt;
        logic acc;
        logic wr;
        logic binit;
        logic bwc;
        logic brv;
        logic bwv;
        logic bdiv;
        logic emit;
    } cwp_cmd_t;

    typedef struct packed {
        logic load_los;
        logic i_last;
        logic j_last;
        logic p_last;
        logic p_zero;
        logic out_acc;
    } cwp_sts_t;

endpackage

// ===== hdl/cwp_ram.sv =====
module cwp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 136
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data <= mem_reg[rd_addr];
    end

endmodule

// ===== hdl/cwp_ctrl.sv =====
module cwp_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  cwp_pkg::cwp_sts_t sts,
    output cwp_pkg::cwp_cmd_t cmd
);
    import cwp_pkg::*;

    typedef enum logic [12:0] {
        ST_IDLE  = 13'b0000000000001,
        ST_INIT  = 13'b0000000000010,
        ST_RD    = 13'b0000000000100,
        ST_WT    = 13'b0000000001000,
        ST_ACC   = 13'b0000000010000,
        ST_WR    = 13'b0000000100000,
        ST_BINIT = 13'b0000001000000,
        ST_BRC   = 13'b0000010000000,
        ST_BWC   = 13'b0000100000000,
        ST_BRV   = 13'b0001000000000,
        ST_BWV   = 13'b0010000000000,
        ST_BDIV  = 13'b0100000000000,
        ST_OUT   = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (sts.load_los) state_next = ST_INIT;
            ST_INIT:  state_next = ST_RD;
            ST_RD:    state_next = ST_WT;
            ST_WT:    state_next = ST_ACC;
            ST_ACC:   state_next = sts.i_last ? ST_WR : ST_RD;
            ST_WR:    state_next = (sts.j_last && sts.p_last) ? ST_BINIT : ST_RD;
            ST_BINIT: state_next = ST_BRC;
            ST_BRC:   state_next = ST_BWC;
            ST_BWC:   state_next = ST_BRV;
            ST_BRV:   state_next = ST_BWV;
            ST_BWV:   state_next = ST_BDIV;
            ST_BDIV:  state_next = ST_OUT;
            ST_OUT: begin
                if (sts.out_acc) state_next = sts.p_zero ? ST_IDLE : ST_BRC;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd       = '0;
        cmd.idle  = (state_reg == ST_IDLE);
        cmd.init  = (state_reg == ST_INIT);
        cmd.rd    = (state_reg == ST_RD);
        cmd.wt    = (state_reg == ST_WT);
        cmd.acc   = (state_reg == ST_ACC);
        cmd.wr    = (state_reg == ST_WR);
        cmd.binit = (state_reg == ST_BINIT);
        cmd.bwc   = (state_reg == ST_BWC);
        cmd.brv   = (state_reg == ST_BRV);
        cmd.bwv   = (state_reg == ST_BWV);
        cmd.bdiv  = (state_reg == ST_BDIV);
        cmd.emit  = (state_reg == ST_OUT);
    end

endmodule

// ===== hdl/cwp_dp.sv =====
module cwp_dp #(
    parameter int MAX_PARTS = 8,
    parameter int MAX_WAYS  = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  cwp_pkg::cwp_cmd_t                 cmd,
    output cwp_pkg::cwp_sts_t                 sts,
    input  logic                              s_tvalid,
    input  logic [cwp_pkg::IN_TDATA_W-1:0]    s_tdata,
    input  logic                              s_tuser,
    input  logic                              s_tlast,
    input  logic                              m_tready,
    output logic [cwp_pkg::OUT_TDATA_W-1:0]   m_tdata,
    output logic                              m_tlast,
    input  logic                              cfg_valid,
    input  logic [cwp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cwp_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import cwp_pkg::*;

    localparam int ROW   = MAX_WAYS + 1;
    localparam int DEPTH = MAX_PARTS * ROW;
    localparam int AW    = $clog2(DEPTH);
    localparam int PIW   = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
    localparam int CNW   = $clog2(MAX_PARTS + 1);
    localparam int WW    = $clog2(MAX_WAYS + 1);
    localparam int CW    = 32 + CNW;

    function automatic logic [AW-1:0] addr_of(input logic [PIW-1:0] p, input logic [WW-1:0] w);
        addr_of = AW'(p) * AW'(ROW) + AW'(w);
    endfunction

    logic [7:0]  in_id;
    logic [4:0]  in_wc;
    logic [15:0] in_mr;
    logic [15:0] in_pw;
    logic        s_fire;
    logic        room;

    logic [4:0]     tw_reg;
    logic [16:0]    sets_reg;
    logic [CNW-1:0] pc_reg;
    logic [15:0]    weight_reg [MAX_PARTS];
    logic [7:0]     id_reg [MAX_PARTS];

    assign in_id  = s_tdata[7:0];
    assign in_wc  = s_tdata[12:8];
    assign in_mr  = s_tdata[28:13];
    assign in_pw  = s_tdata[44:29];
    assign s_fire = s_tvalid & cmd.idle;
    assign room   = (pc_reg < CNW'(MAX_PARTS));

    logic [PIW-1:0] p_reg;
    logic [WW-1:0]  j_reg, i_reg, t_reg, rest_reg, bi_reg, w_reg;
    logic [CW-1:0]  best_reg, prev_reg;
    logic [31:0]    prod_reg;
    logic [LINES_W-1:0] lines_reg;
    logic [X_W-1:0] hx_reg, lx_reg;
    logic [15:0]    ratio_reg;

    logic [7:0]  out_id_reg;
    logic [4:0]  out_ways_reg;
    logic [20:0] out_max_reg;
    logic [19:0] out_min_reg;
    logic [15:0] out_ratio_reg;
    logic        out_last_reg;

    logic [15:0]    curve_rd;
    logic [CW-1:0]  cost_rd;
    logic [WW-1:0]  choice_rd;
    logic           curve_we;
    logic [AW-1:0]  curve_wa, curve_ra, cost_ra, wr_a, choice_ra;
    logic [CW-1:0]  cand;
    logic           first;
    logic [WW-1:0]  t_calc;
    logic [PIW-1:0] p_prev;
    logic [PROD_W-1:0] hq_full, lq_full;
    logic [23:0]    hq, lq;

    assign curve_we  = s_fire & room & ({1'b0, in_wc} <= 6'(MAX_WAYS));
    assign curve_wa  = addr_of(pc_reg[PIW-1:0], WW'(in_wc));
    assign curve_ra  = cmd.rd ? addr_of(p_reg, i_reg) : addr_of(p_reg, w_reg);
    assign p_prev    = p_reg - PIW'(1);
    assign cost_ra   = addr_of(p_prev, j_reg - i_reg);
    assign wr_a      = addr_of(p_reg, j_reg);
    assign choice_ra = addr_of(p_reg, rest_reg);

    assign cand   = CW'(prod_reg) + prev_reg;
    assign first  = (p_reg == '0) || (i_reg == '0);
    assign t_calc = ({1'b0, tw_reg} > 6'(MAX_WAYS)) ? WW'(MAX_WAYS) : WW'(tw_reg);

    assign hq_full = PROD_W'(hx_reg[X_W-1:2]) * PROD_W'(DIV25_MAG);
    assign lq_full = PROD_W'(lx_reg[X_W-1:2]) * PROD_W'(DIV25_MAG);
    assign hq      = hq_full[PROD_W-1:32];
    assign lq      = lq_full[PROD_W-1:32];

    cwp_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_curve (
        .aclk(aclk), .wr_en(curve_we), .wr_addr(curve_wa), .wr_data(in_mr),
        .rd_addr(curve_ra), .rd_data(curve_rd)
    );

    cwp_ram #(.WIDTH(CW), .DEPTH(DEPTH)) u_cost (
        .aclk(aclk), .wr_en(cmd.wr), .wr_addr(wr_a), .wr_data(best_reg),
        .rd_addr(cost_ra), .rd_data(cost_rd)
    );

    cwp_ram #(.WIDTH(WW), .DEPTH(DEPTH)) u_choice (
        .aclk(aclk), .wr_en(cmd.wr), .wr_addr(wr_a), .wr_data(bi_reg),
        .rd_addr(choice_ra), .rd_data(choice_rd)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tw_reg   <= TOTAL_WAYS_RST;
            sets_reg <= SETS_RST;
            pc_reg   <= '0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_TOTAL_WAYS: tw_reg   <= cfg_data[4:0];
                    CFG_SETS:       sets_reg <= cfg_data;
                    default:        ;
                endcase
            end
            if (s_fire && room && (s_tuser || s_tlast)) begin
                pc_reg <= pc_reg + CNW'(1);
            end else if (cmd.emit && m_tready && p_reg == '0) begin
                pc_reg <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire && room) begin
            weight_reg[pc_reg[PIW-1:0]] <= in_pw;
            id_reg[pc_reg[PIW-1:0]]     <= in_id;
        end
        if (cmd.init) begin
            p_reg <= '0;
            j_reg <= '0;
            i_reg <= '0;
            t_reg <= t_calc;
        end
        if (cmd.wt) begin
            prod_reg <= 32'(curve_rd) * 32'(weight_reg[p_reg]);
            prev_reg <= (p_reg == '0) ? '0 : cost_rd;
        end
        if (cmd.acc) begin
            if (first || cand < best_reg) begin
                best_reg <= cand;
                bi_reg   <= i_reg;
            end
            if (i_reg != j_reg) i_reg <= i_reg + WW'(1);
        end
        if (cmd.wr) begin
            if (j_reg == t_reg) begin
                p_reg <= p_reg + PIW'(1);
                j_reg <= '0;
                i_reg <= '0;
            end else begin
                j_reg <= j_reg + WW'(1);
                i_reg <= (p_reg == '0) ? j_reg + WW'(1) : '0;
            end
        end
        if (cmd.binit) begin
            p_reg    <= PIW'(pc_reg - CNW'(1));
            rest_reg <= t_reg;
        end
        if (cmd.bwc) w_reg <= choice_rd;
        if (cmd.brv) lines_reg <= LINES_W'(w_reg) * LINES_W'(sets_reg);
        if (cmd.bwv) begin
            ratio_reg <= curve_rd;
            hx_reg    <= X_W'(lines_reg) * X_W'(MUL_HI);
            lx_reg    <= X_W'(lines_reg) * X_W'(MUL_LO);
        end
        if (cmd.bdiv) begin
            out_id_reg    <= id_reg[p_reg];
            out_ways_reg  <= 5'(w_reg);
            out_max_reg   <= (|hq[23:21]) ? '1 : hq[20:0];
            out_min_reg   <= (|lq[23:20]) ? '1 : lq[19:0];
            out_ratio_reg <= ratio_reg;
            out_last_reg  <= (p_reg == '0);
        end
        if (cmd.emit && m_tready) begin
            rest_reg <= rest_reg - w_reg;
            if (p_reg != '0) p_reg <= p_reg - PIW'(1);
        end
    end

    assign sts.load_los = s_fire & s_tlast;
    assign sts.i_last   = (i_reg == j_reg);
    assign sts.j_last   = (j_reg == t_reg);
    assign sts.p_last   = (CNW'(p_reg) == pc_reg - CNW'(1));
    assign sts.p_zero   = (p_reg == '0);
    assign sts.out_acc  = cmd.emit & m_tready;

    assign m_tdata = {2'b00, out_ratio_reg, out_min_reg, out_max_reg, out_ways_reg, out_id_reg};
    assign m_tlast = out_last_reg;

endmodule

// ===== hdl/cache_way_partition_dp.sv =====
// Loading: one curve entry per cycle; the entry carrying tlast starts the solve.
// Solve: each candidate split passes through the RD, WT and ACC states and each (partition, way)
// cell is then written in WR; the serial candidate scan sets the solve time.
// Results: one per partition via BRC, BWC, BRV, BWV, BDIV; a stalled sink holds it.
// Reset (aresetn low, synchronous): total_ways 16, sets_per_way 1024, no partitions.
module cache_way_partition_dp #(
    parameter int MAX_PARTS = 8,
    parameter int MAX_WAYS  = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // partition_id, way_count, miss_ratio, penalty_weight, zero pad
    input  logic [cwp_pkg::IN_TDATA_W-1:0]   s_tdata,
    // last_of_curve
    input  logic                             s_tuser,
    input  logic                             s_tlast,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // out_partition_id, ways_given, max_lines, min_lines, ideal_miss_ratio, zero pad
    output logic [cwp_pkg::OUT_TDATA_W-1:0]  m_tdata,
    output logic                             m_tlast,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [cwp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cwp_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import cwp_pkg::*;

    cwp_cmd_t cmd;
    cwp_sts_t sts;

    cwp_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .sts(sts), .cmd(cmd)
    );

    cwp_dp #(.MAX_PARTS(MAX_PARTS), .MAX_WAYS(MAX_WAYS)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .sts(sts),
        .s_tvalid(s_tvalid), .s_tdata(s_tdata), .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    assign s_tready  = cmd.idle;
    assign m_tvalid  = cmd.emit;
    assign cfg_ready = 1'b1;

endmodule

// ===== hdl/cwp_check.sv =====
`include "cache_way_partition_dp_assert.svh"

module cwp_check (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic        m_tlast,
    input logic [71:0] m_tdata
);

    `CWP_ASSERT_SAME(a_no_overlap, m_tvalid, !s_tready, "load accepted while result pending")
    `CWP_ASSERT_NEXT(a_solve_start, s_tvalid && s_tready && s_tlast, !s_tready, "load continued after set end")
    `CWP_ASSERT_NEXT(a_run_end, m_tvalid && m_tready && m_tlast, !m_tvalid, "result after final one")
    `CWP_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")

endmodule

bind cache_way_partition_dp cwp_check u_cwp_check (
    .aclk(aclk), .aresetn(aresetn),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tlast(m_tlast), .m_tdata(m_tdata)
);
